// File: hw/rtl/sha1bc_pkg.sv
package sha1bc_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned CHAIN_N   = 5;
	localparam int unsigned BLOCK_N   = 16;
	localparam int unsigned ROUNDS    = 80;
	localparam int unsigned ROUND_W   = $clog2(ROUNDS);
	localparam int unsigned POS_W     = $clog2(BLOCK_N);
	localparam int unsigned WNUM_W    = 3;

	typedef logic [WORD_W-1:0] word_t;

	localparam word_t IV [CHAIN_N] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam word_t K0 = 32'h5a827999;
	localparam word_t K1 = 32'h6ed9eba1;
	localparam word_t K2 = 32'h8f1bbcdc;
	localparam word_t K3 = 32'hca62c1d6;

	typedef enum logic [3:0] {
		S_LOAD  = 4'b0001,
		S_ROUND = 4'b0010,
		S_ADD   = 4'b0100,
		S_OUT   = 4'b1000
	} state_t;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		return (x << n) | (x >> (WORD_W - n));
	endfunction

	function automatic word_t round_k(input logic [ROUND_W-1:0] t);
		word_t k;
		priority if (t < ROUND_W'(20)) k = K0;
		else if (t < ROUND_W'(40)) k = K1;
		else if (t < ROUND_W'(60)) k = K2;
		else k = K3;
		return k;
	endfunction

	function automatic word_t round_f(input logic [ROUND_W-1:0] t, input word_t b,
			input word_t c, input word_t d);
		word_t f;
		priority if (t < ROUND_W'(20)) f = (b & c) | (~b & d);
		else if (t < ROUND_W'(40)) f = b ^ c ^ d;
		else if (t < ROUND_W'(60)) f = (b & c) | (b & d) | (c & d);
		else f = b ^ c ^ d;
		return f;
	endfunction

endpackage

// File: hw/rtl/sha1_block_compressor.sv
// A block's 16th word is followed by the 80 rounds in S_ROUND, one chaining add in
// S_ADD, then five digest transactions in S_OUT.
// Throughput: one round per cycle on the shared round unit.
// Input stall is high from the 16th word until the fifth digest word is taken.
// Reset (arst_n low) loads the initial vector, clears word position and returns state to S_LOAD.
module sha1_block_compressor
	import sha1bc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [31:0]       message_word,
	input  logic              start_message,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       digest_word,
	output logic [2:0]        word_number,
	output logic              last_word
);

	state_t               state_q;
	word_t                chain_q [CHAIN_N];
	word_t                w_q [BLOCK_N];
	word_t                a_q, b_q, c_q, d_q, e_q;
	logic [POS_W-1:0]     pos_q;
	logic [ROUND_W-1:0]   round_q;
	logic [WNUM_W-1:0]    oidx_q;

	logic  in_acc, out_acc, block_done;
	word_t w_next, round_sum;

	assign in_stall  = (state_q != S_LOAD);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT);
	assign out_acc   = out_valid && !out_stall;

	// A start flag makes this word 0, so it can never close a block
	assign block_done = in_acc && !start_message && (pos_q == POS_W'(BLOCK_N - 1));

	// Window w_q[k] holds W[t+k]; expand the schedule one word per round
	assign w_next = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);

	assign round_sum = rotl(a_q, 5) + round_f(round_q, b_q, c_q, d_q) + e_q
		+ round_k(round_q) + w_q[0];

	assign digest_word = chain_q[oidx_q];
	assign word_number = oidx_q;
	assign last_word   = (oidx_q == WNUM_W'(CHAIN_N - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			pos_q   <= '0;
			round_q <= '0;
			oidx_q  <= '0;
			for (int i = 0; i < CHAIN_N; i++) chain_q[i] <= IV[i];
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (start_message) begin
							for (int i = 0; i < CHAIN_N; i++) chain_q[i] <= IV[i];
							pos_q <= POS_W'(1);
						end else begin
							pos_q <= pos_q + POS_W'(1);
						end
						if (block_done) begin
							round_q <= '0;
							state_q <= S_ROUND;
						end
					end
				end
				S_ROUND: begin
					if (round_q == ROUND_W'(ROUNDS - 1)) state_q <= S_ADD;
					round_q <= round_q + ROUND_W'(1);
				end
				S_ADD: begin
					chain_q[0] <= chain_q[0] + a_q;
					chain_q[1] <= chain_q[1] + b_q;
					chain_q[2] <= chain_q[2] + c_q;
					chain_q[3] <= chain_q[3] + d_q;
					chain_q[4] <= chain_q[4] + e_q;
					oidx_q     <= '0;
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (out_acc) begin
						if (last_word) state_q <= S_LOAD;
						oidx_q <= oidx_q + WNUM_W'(1);
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// Datapath registers: schedule window and working variables
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < BLOCK_N - 1; i++) w_q[i] <= w_q[i+1];
			w_q[BLOCK_N-1] <= message_word;
		end else if (state_q == S_ROUND) begin
			for (int i = 0; i < BLOCK_N - 1; i++) w_q[i] <= w_q[i+1];
			w_q[BLOCK_N-1] <= w_next;
		end
		if (block_done) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == S_ROUND) begin
			a_q <= round_sum;
			b_q <= a_q;
			c_q <= rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule
